>>> hw/rtl/gcb_pkg.sv
package gcb_pkg;

    localparam logic [31:0] RB_MASK      = 32'h00FF_00FF;
    localparam logic [31:0] G_MASK       = 32'h0000_FF00;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [7:0]  FULL_COVER   = 8'd255;
    localparam logic [7:0]  NO_COVER     = 8'd0;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        REG_CELL_WIDTH    = 2'd0,
        REG_CELL_HEIGHT   = 2'd1,
        REG_CELL_BASELINE = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    localparam logic [7:0] CELL_WIDTH_RST    = 8'd8;
    localparam logic [7:0] CELL_HEIGHT_RST   = 8'd16;
    localparam logic [7:0] CELL_BASELINE_RST = 8'd12;

    typedef struct packed {
        logic [7:0] cell_width;
        logic [7:0] cell_height;
        logic [7:0] cell_baseline;
    } cell_cfg_t;

    // first member sits in the highest bits
    typedef struct packed {
        logic [31:0]       back_argb;
        logic [31:0]       fore_argb;
        logic signed [8:0] glyph_top;
        logic [7:0]        glyph_height;
        logic [7:0]        glyph_width;
        logic [7:0]        src_row;
        logic [7:0]        src_col;
        logic [7:0]        coverage;
    } sample_t;

    typedef struct packed {
        logic        keep;
        logic [15:0] index;
    } place_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [15:0] cell_index;
    } result_t;

endpackage

>>> hw/rtl/gcb_place.sv
module gcb_place
(
    input  gcb_pkg::cell_cfg_t cfg,
    input  logic [7:0]         src_col,
    input  logic [7:0]         src_row,
    input  logic [7:0]         glyph_width,
    input  logic [7:0]         glyph_height,
    input  logic signed [8:0]  glyph_top,
    output gcb_pkg::place_t    place
);
    import gcb_pkg::*;

    logic [7:0]         span;
    logic [7:0]         x_off;
    logic [7:0]         room;
    logic [7:0]         vis_w;
    logic [8:0]         dcol;
    logic signed [10:0] drow;
    logic [15:0]        row_base;
    logic               keep;

    assign span  = cfg.cell_width - glyph_width;
    assign x_off = (glyph_width < cfg.cell_width) ? {1'b0, span[7:1]} : 8'd0;
    assign room  = cfg.cell_width - x_off;
    assign vis_w = (glyph_width < room) ? glyph_width : room;
    assign dcol  = {1'b0, x_off} + {1'b0, src_col};

    assign drow = $signed({3'b000, src_row}) + $signed({3'b000, cfg.cell_baseline})
                - $signed({{2{glyph_top[8]}}, glyph_top});

    assign keep = (src_col < vis_w) && (src_row < glyph_height) && !drow[10]
               && (drow[9:0] < {2'b00, cfg.cell_height});

    assign row_base = {8'd0, drow[7:0]} * {8'd0, cfg.cell_width};

    assign place.keep  = keep;
    assign place.index = keep ? (row_base + {7'd0, dcol}) : 16'd0;

endmodule

>>> hw/rtl/gcb_blend.sv
module gcb_blend
(
    input  logic [7:0]  coverage,
    input  logic [31:0] fore_argb,
    input  logic [31:0] back_argb,
    output logic [31:0] pixel_color
);
    import gcb_pkg::*;

    logic [31:0] bg_rb;
    logic [31:0] bg_g;
    logic [31:0] diff_rb;
    logic [31:0] diff_g;
    logic [31:0] prod_rb;
    logic [31:0] prod_g;
    logic [31:0] mix_rb;
    logic [31:0] mix_g;

    assign bg_rb   = back_argb & RB_MASK;
    assign bg_g    = back_argb & G_MASK;
    assign diff_rb = (fore_argb & RB_MASK) - bg_rb;
    assign diff_g  = (fore_argb & G_MASK) - bg_g;

    // 32-bit wrapping products
    assign prod_rb = diff_rb * {24'd0, coverage};
    assign prod_g  = diff_g * {24'd0, coverage};

    assign mix_rb = (prod_rb >> 8) + bg_rb;
    assign mix_g  = (prod_g >> 8) + bg_g;

    always_comb
    begin
        if (coverage == NO_COVER)
        begin
            pixel_color = back_argb;
        end
        else if (coverage == FULL_COVER)
        begin
            pixel_color = fore_argb;
        end
        else
        begin
            pixel_color = (mix_rb & RB_MASK) | (mix_g & G_MASK) | ALPHA_OPAQUE;
        end
    end

endmodule

>>> hw/rtl/glyph_cell_blend_blit_core.sv
// Glyph cell blend/blit: takes one glyph coverage sample per word and returns one
// colored pixel per word with its index in the character cell (row * cell_width + col);
// clipped samples come back with write_enable (m_tuser) low and zero data.
// The glyph is centered horizontally and its top row lands at cell_baseline - glyph_top.
// Words pass through two registers (input register, result register) and a new word
// is taken every cycle while the output is not stalled by m_tready; throughput is one
// word per clock then, with the color multiplies and index multiply between the registers.
// Cell registers are written through cfg_we/cfg_addr/cfg_data and should only
// change while no word is in flight.
module glyph_cell_blend_blit_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [7:0]                      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // coverage[7:0], src_col[15:8], src_row[23:16], glyph_width[31:24],
    // glyph_height[39:32], glyph_top[48:40], fore_argb[80:49], back_argb[112:81]
    input  logic [gcb_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_index[15:0], pixel_color[47:16]
    output logic [gcb_pkg::OUT_DATA_W-1:0] m_tdata,
    // write_enable[0]
    output logic                            m_tuser
);
    import gcb_pkg::*;

    cell_cfg_t cfg_reg;
    logic      in_valid_reg;
    sample_t   in_reg;
    logic      out_valid_reg;
    result_t   out_reg;
    logic      out_we_reg;

    logic      out_adv;
    logic      in_adv;
    place_t    place;
    logic [31:0] blended;
    result_t   result_next;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width    <= CELL_WIDTH_RST;
            cfg_reg.cell_height   <= CELL_HEIGHT_RST;
            cfg_reg.cell_baseline <= CELL_BASELINE_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_CELL_WIDTH:    cfg_reg.cell_width    <= cfg_data;
                REG_CELL_HEIGHT:   cfg_reg.cell_height   <= cfg_data;
                REG_CELL_BASELINE: cfg_reg.cell_baseline <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && s_tvalid)
        begin
            in_reg <= sample_t'(s_tdata[$bits(sample_t)-1:0]);
        end
        if (out_adv && in_valid_reg)
        begin
            out_reg    <= result_next;
            out_we_reg <= place.keep;
        end
    end

    gcb_place u_place
    (
        .cfg          (cfg_reg),
        .src_col      (in_reg.src_col),
        .src_row      (in_reg.src_row),
        .glyph_width  (in_reg.glyph_width),
        .glyph_height (in_reg.glyph_height),
        .glyph_top    (in_reg.glyph_top),
        .place        (place)
    );

    gcb_blend u_blend
    (
        .coverage    (in_reg.coverage),
        .fore_argb   (in_reg.fore_argb),
        .back_argb   (in_reg.back_argb),
        .pixel_color (blended)
    );

    assign result_next.cell_index  = place.index;
    assign result_next.pixel_color = place.keep ? blended : 32'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = out_we_reg;

endmodule

>>> hw/rtl/gcb_checker.sv
module gcb_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gcb_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("clipped word carries nonzero data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_ready_when_empty: assert property (@(posedge clk)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind glyph_cell_blend_blit_core gcb_checker u_gcb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
